[hdl/rcd_pkg.sv]
// rcd_pkg: types, constants and helpers shared by the frame decoder modules
// no dependencies

package rcd_pkg;

	localparam int HEAD_LEN        = 12;
	localparam int HEAD_IDX_W      = 4;
	localparam int COUNT_W         = 7;
	localparam int COUNT_MAX       = 127;
	localparam int MAX_FRAME_BYTES = 64;

	localparam logic [7:0] HDR_BYTE0   = 8'h03;
	localparam logic [7:0] HDR_BYTE1   = 8'h01;
	localparam logic [7:0] MARKER_BYTE = 8'h18;
	localparam logic [7:0] ID_MASK     = 8'hFC;
	localparam logic [7:0] YAW_ID_MASK = 8'hF8;

	localparam int STICK_CENTRE = 511;
	localparam int THR_OFFSET   = 424;

	// divide by 360: (mag*4096 + 180) >> 3 = mag*512 + 22, then / 45
	localparam int          STICK_BIAS  = 22;
	localparam int          STICK_SHIFT = 24;
	localparam logic [18:0] STICK_RECIP = 19'd372828;
	// divide by 400: (mag*4096 + 200) >> 4 = mag*256 + 12, then / 25
	localparam int          THR_BIAS    = 12;
	localparam int          THR_SHIFT   = 22;
	localparam logic [17:0] THR_RECIP   = 18'd167773;

	localparam int QW = 13;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THROTTLE_ID       = 3'd0,
		REG_ROLL_ID           = 3'd1,
		REG_PITCH_ID          = 3'd2,
		REG_YAW_ID            = 3'd3,
		REG_AUTO_ID           = 3'd4,
		REG_AUTO_THRESHOLD    = 3'd5,
		REG_THROTTLE_DEADBAND = 3'd6,
		REG_STICK_DEADBAND    = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		YAW_ZERO = 2'b00,
		YAW_LOW  = 2'b01,
		YAW_MID  = 2'b10,
		YAW_HIGH = 2'b11
	} yaw_range_t;

	typedef struct packed {
		logic [7:0]  throttle_id;
		logic [7:0]  roll_id;
		logic [7:0]  pitch_id;
		logic [7:0]  yaw_id;
		logic [7:0]  auto_id;
		logic [9:0]  auto_threshold;
		logic [14:0] throttle_deadband;
		logic [14:0] stick_deadband;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
	} byte_item_t;

	typedef struct packed {
		logic signed [15:0] throttle_out;
		logic signed [15:0] roll_out;
		logic signed [15:0] pitch_out;
		logic signed [15:0] yaw_out;
		logic               aux_flag;
		logic               auto_flag;
		logic               sticks_idle;
		logic               frame_accepted;
	} result_t;

	// per channel update flags
	typedef struct packed {
		logic thr;
		logic roll;
		logic pitch;
		logic yaw;
		logic auto_ch;
	} match_t;

	typedef struct packed {
		logic thr;
		logic roll;
		logic pitch;
		logic yaw;
	} neg_t;

	typedef struct packed {
		logic        ok;
		match_t      hit;
		neg_t        neg;
		logic        auto_val;
		logic        aux_val;
		logic [17:0] m_thr;
		logic [18:0] m_roll;
		logic [18:0] m_pitch;
		logic [18:0] m_yaw;
	} prep_t;

	typedef struct packed {
		logic          ok;
		match_t        hit;
		neg_t          neg;
		logic          auto_val;
		logic          aux_val;
		logic [QW-1:0] q_thr;
		logic [QW-1:0] q_roll;
		logic [QW-1:0] q_pitch;
		logic [QW-1:0] q_yaw;
	} scaled_t;

	function automatic logic signed [15:0] dead_band(input logic signed [15:0] r,
			input logic [14:0] h);
		logic signed [16:0] rx;
		logic signed [16:0] hp;
		logic signed [16:0] hn;
		logic signed [16:0] res;
		rx = {r[15], r};
		hp = $signed({2'b00, h});
		hn = -hp;
		if (rx > hn && rx < hp) begin
			res = '0;
		end else if (rx > hp) begin
			res = rx - hp;
		end else if (rx < hn) begin
			res = rx + hp;
		end else begin
			res = rx;
		end
		return res[15:0];
	endfunction

	function automatic logic signed [15:0] apply_sign(input logic [QW-1:0] q,
			input logic neg);
		logic signed [15:0] v;
		v = $signed({3'b000, q});
		return neg ? -v : v;
	endfunction

endpackage

[hdl/rcd_if.sv]
// rcd_if: valid/ready stream interfaces for frame bytes and decoded results
// depends on rcd_pkg

interface rcd_byte_if;
	logic                valid;
	logic                ready;
	rcd_pkg::byte_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface rcd_result_if;
	logic             valid;
	logic             ready;
	rcd_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hdl/rcd_cfg_regs.sv]
// rcd_cfg_regs: configuration register file written through a plain write port
// depends on rcd_pkg

module rcd_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [rcd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rcd_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
	output rcd_pkg::cfg_t                      cfg
);

	rcd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.throttle_id       <= 8'd0;
			cfg_q.roll_id           <= 8'd4;
			cfg_q.pitch_id          <= 8'd8;
			cfg_q.yaw_id            <= 8'd24;
			cfg_q.auto_id           <= 8'd20;
			cfg_q.auto_threshold    <= 10'd180;
			cfg_q.throttle_deadband <= 15'd819;
			cfg_q.stick_deadband    <= 15'd205;
		end else if (cfg_wr_en) begin
			case (rcd_pkg::reg_idx_t'(cfg_index))
				rcd_pkg::REG_THROTTLE_ID:       cfg_q.throttle_id <= cfg_wr_data[7:0];
				rcd_pkg::REG_ROLL_ID:           cfg_q.roll_id <= cfg_wr_data[7:0];
				rcd_pkg::REG_PITCH_ID:          cfg_q.pitch_id <= cfg_wr_data[7:0];
				rcd_pkg::REG_YAW_ID:            cfg_q.yaw_id <= cfg_wr_data[7:0];
				rcd_pkg::REG_AUTO_ID:           cfg_q.auto_id <= cfg_wr_data[7:0];
				rcd_pkg::REG_AUTO_THRESHOLD:    cfg_q.auto_threshold <= cfg_wr_data[9:0];
				rcd_pkg::REG_THROTTLE_DEADBAND: cfg_q.throttle_deadband <= cfg_wr_data;
				rcd_pkg::REG_STICK_DEADBAND:    cfg_q.stick_deadband <= cfg_wr_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/rcd_frame_capture.sv]
// rcd_frame_capture: input register, head byte store, byte count and frame checks
// produces the pre-scaled channel magnitudes for the last byte; depends on rcd_pkg, rcd_if

module rcd_frame_capture #(
	parameter int MAX_FRAME_BYTES = rcd_pkg::MAX_FRAME_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rcd_pkg::cfg_t        cfg,
	rcd_byte_if.sink             byte_in,
	output logic                 valid_s2,
	output rcd_pkg::prep_t       prep_s2,
	input  logic                 ready_dn
);

	logic                               valid_s1;
	rcd_pkg::byte_item_t                byte_s1;
	logic [7:0]                         head_q [rcd_pkg::HEAD_LEN];
	logic [rcd_pkg::COUNT_W-1:0]        count_q;
	logic [7:0]                         prev_q;

	logic                               s2_free;
	logic                               adv_s1;
	logic                               end_to_s2;
	logic [7:0]                         hv [rcd_pkg::HEAD_LEN];
	logic [rcd_pkg::COUNT_W-1:0]        len;
	logic                               ok;
	logic [9:0]                         v_roll;
	logic [9:0]                         v_pitch;
	logic [9:0]                         v_thr;
	logic [9:0]                         v_auto;
	logic signed [11:0]                 d_roll;
	logic signed [11:0]                 d_pitch;
	logic signed [11:0]                 d_thr;
	logic signed [11:0]                 a_roll;
	logic signed [11:0]                 a_pitch;
	logic signed [11:0]                 a_thr;
	logic [9:0]                         mag_yaw;
	logic                               yaw_pos;
	rcd_pkg::prep_t                     prep;

	assign s2_free      = !valid_s2 || ready_dn;
	assign adv_s1       = valid_s1 && (!byte_s1.frame_end || s2_free);
	assign end_to_s2    = adv_s1 && byte_s1.frame_end;
	assign byte_in.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_s1 <= byte_in.payload;
		end
	end

	// head store, written once for each head position of a frame
	always_ff @(posedge clk) begin
		if (adv_s1 && count_q < rcd_pkg::COUNT_W'(rcd_pkg::HEAD_LEN)) begin
			head_q[count_q[rcd_pkg::HEAD_IDX_W-1:0]] <= byte_s1.data_byte;
		end
	end

	always_comb begin
		for (int i = 0; i < rcd_pkg::HEAD_LEN; i++) begin
			hv[i] = (count_q == rcd_pkg::COUNT_W'(i)) ? byte_s1.data_byte : head_q[i];
		end
	end

	assign len = (count_q == rcd_pkg::COUNT_W'(rcd_pkg::COUNT_MAX)) ? count_q
		: count_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			prev_q  <= '0;
		end else if (adv_s1) begin
			count_q <= byte_s1.frame_end ? '0 : len;
			prev_q  <= byte_s1.data_byte;
		end
	end

	assign ok = len >= rcd_pkg::COUNT_W'(rcd_pkg::HEAD_LEN)
		&& len <= rcd_pkg::COUNT_W'(MAX_FRAME_BYTES)
		&& hv[0] == rcd_pkg::HDR_BYTE0 && hv[1] == rcd_pkg::HDR_BYTE1
		&& prev_q == rcd_pkg::MARKER_BYTE;

	assign v_roll  = {hv[2][1:0], hv[3]};
	assign v_auto  = {hv[4][1:0], hv[5]};
	assign v_pitch = {hv[6][1:0], hv[7]};
	assign v_thr   = {hv[10][1:0], hv[11]};

	assign d_roll  = $signed({2'b00, v_roll}) - 12'sd511;
	assign d_pitch = $signed({2'b00, v_pitch}) - 12'sd511;
	assign d_thr   = $signed({2'b00, v_thr}) - 12'sd424;
	assign a_roll  = d_roll[11] ? -d_roll : d_roll;
	assign a_pitch = d_pitch[11] ? -d_pitch : d_pitch;
	assign a_thr   = d_thr[11] ? -d_thr : d_thr;

	// yaw four-way range decode (zero, low, mid, high) on bits 10:9 of the 11 bit word
	always_comb begin
		case (rcd_pkg::yaw_range_t'(hv[8][2:1]))
			rcd_pkg::YAW_HIGH: begin
				mag_yaw = {hv[8][0], hv[9]};
				yaw_pos = 1'b1;
			end
			rcd_pkg::YAW_LOW: begin
				mag_yaw = 10'd255 - {2'b00, hv[9]};
				yaw_pos = 1'b0;
			end
			rcd_pkg::YAW_MID: begin
				mag_yaw = 10'd510 - {2'b00, hv[9]};
				yaw_pos = 1'b0;
			end
			default: begin
				mag_yaw = '0;
				yaw_pos = 1'b0;
			end
		endcase
	end

	always_comb begin
		prep.ok          = ok;
		prep.hit.thr     = (hv[10] & rcd_pkg::ID_MASK) == cfg.throttle_id;
		prep.hit.roll    = (hv[2] & rcd_pkg::ID_MASK) == cfg.roll_id;
		prep.hit.pitch   = (hv[6] & rcd_pkg::ID_MASK) == cfg.pitch_id;
		prep.hit.yaw     = (hv[8] & rcd_pkg::YAW_ID_MASK) == cfg.yaw_id;
		prep.hit.auto_ch = (hv[4] & rcd_pkg::ID_MASK) == cfg.auto_id;
		prep.neg.thr     = d_thr[11];
		prep.neg.roll    = d_roll[11];
		prep.neg.pitch   = !d_pitch[11];
		prep.neg.yaw     = yaw_pos;
		prep.auto_val    = !(v_auto > cfg.auto_threshold);
		prep.aux_val     = len != rcd_pkg::COUNT_W'(16);
		prep.m_thr       = {a_thr[9:0], 8'b0} + 18'(rcd_pkg::THR_BIAS);
		prep.m_roll      = {a_roll[9:0], 9'b0} + 19'(rcd_pkg::STICK_BIAS);
		prep.m_pitch     = {a_pitch[9:0], 9'b0} + 19'(rcd_pkg::STICK_BIAS);
		prep.m_yaw       = {mag_yaw, 9'b0} + 19'(rcd_pkg::STICK_BIAS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= end_to_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (end_to_s2) begin
			prep_s2 <= prep;
		end
	end

endmodule

[hdl/rcd_scale.sv]
// rcd_scale: rounded constant division of the channel magnitudes by reciprocal multiply
// depends on rcd_pkg

module rcd_scale (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s2,
	input  rcd_pkg::prep_t    prep_s2,
	output logic              ready_s2,
	output logic              valid_s3,
	output rcd_pkg::scaled_t  scaled_s3,
	input  logic              ready_dn
);

	logic [35:0]      p_thr;
	logic [37:0]      p_roll;
	logic [37:0]      p_pitch;
	logic [37:0]      p_yaw;
	logic             load;
	rcd_pkg::scaled_t nxt;

	assign ready_s2 = !valid_s3 || ready_dn;
	assign load     = valid_s2 && ready_s2;

	assign p_thr   = prep_s2.m_thr * rcd_pkg::THR_RECIP;
	assign p_roll  = prep_s2.m_roll * rcd_pkg::STICK_RECIP;
	assign p_pitch = prep_s2.m_pitch * rcd_pkg::STICK_RECIP;
	assign p_yaw   = prep_s2.m_yaw * rcd_pkg::STICK_RECIP;

	always_comb begin
		nxt.ok       = prep_s2.ok;
		nxt.hit      = prep_s2.hit;
		nxt.neg      = prep_s2.neg;
		nxt.auto_val = prep_s2.auto_val;
		nxt.aux_val  = prep_s2.aux_val;
		nxt.q_thr    = p_thr[rcd_pkg::THR_SHIFT +: rcd_pkg::QW];
		nxt.q_roll   = p_roll[rcd_pkg::STICK_SHIFT +: rcd_pkg::QW];
		nxt.q_pitch  = p_pitch[rcd_pkg::STICK_SHIFT +: rcd_pkg::QW];
		nxt.q_yaw    = p_yaw[rcd_pkg::STICK_SHIFT +: rcd_pkg::QW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s2) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			scaled_s3 <= nxt;
		end
	end

endmodule

[hdl/rcd_ref_update.sv]
// rcd_ref_update: stored references, deadband and the result output register
// depends on rcd_pkg, rcd_if

module rcd_ref_update (
	input  logic              clk,
	input  logic              arst_n,
	input  rcd_pkg::cfg_t     cfg,
	input  logic              valid_s3,
	input  rcd_pkg::scaled_t  scaled_s3,
	output logic              ready_s3,
	rcd_result_if.source      result_out
);

	logic signed [15:0] thr_q;
	logic signed [15:0] roll_q;
	logic signed [15:0] pitch_q;
	logic signed [15:0] yaw_q;
	logic               aux_q;
	logic               auto_q;
	logic               out_valid_q;
	rcd_pkg::result_t   out_q;

	logic               load;
	logic               upd;
	logic signed [15:0] thr_n;
	logic signed [15:0] roll_n;
	logic signed [15:0] pitch_n;
	logic signed [15:0] yaw_n;
	logic               aux_n;
	logic               auto_n;
	rcd_pkg::result_t   res;

	assign ready_s3 = !out_valid_q || result_out.ready;
	assign load     = valid_s3 && ready_s3;
	assign upd      = scaled_s3.ok;

	always_comb begin
		thr_n   = (upd && scaled_s3.hit.thr)
			? rcd_pkg::apply_sign(scaled_s3.q_thr, scaled_s3.neg.thr) : thr_q;
		roll_n  = (upd && scaled_s3.hit.roll)
			? rcd_pkg::apply_sign(scaled_s3.q_roll, scaled_s3.neg.roll) : roll_q;
		pitch_n = (upd && scaled_s3.hit.pitch)
			? rcd_pkg::apply_sign(scaled_s3.q_pitch, scaled_s3.neg.pitch) : pitch_q;
		yaw_n   = (upd && scaled_s3.hit.yaw)
			? rcd_pkg::apply_sign(scaled_s3.q_yaw, scaled_s3.neg.yaw) : yaw_q;
		auto_n  = (upd && scaled_s3.hit.auto_ch) ? scaled_s3.auto_val : auto_q;
		aux_n   = upd ? scaled_s3.aux_val : aux_q;

		res.throttle_out   = rcd_pkg::dead_band(thr_n, cfg.throttle_deadband);
		res.roll_out       = rcd_pkg::dead_band(roll_n, cfg.stick_deadband);
		res.pitch_out      = rcd_pkg::dead_band(pitch_n, cfg.stick_deadband);
		res.yaw_out        = rcd_pkg::dead_band(yaw_n, cfg.stick_deadband);
		res.aux_flag       = aux_n;
		res.auto_flag      = auto_n;
		res.sticks_idle    = res.throttle_out == '0 && res.roll_out == '0
			&& res.pitch_out == '0 && res.yaw_out == '0 && !auto_n;
		res.frame_accepted = scaled_s3.ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= '0;
			roll_q  <= '0;
			pitch_q <= '0;
			yaw_q   <= '0;
			aux_q   <= 1'b0;
			auto_q  <= 1'b0;
		end else if (load) begin
			thr_q   <= thr_n;
			roll_q  <= roll_n;
			pitch_q <= pitch_n;
			yaw_q   <= yaw_n;
			aux_q   <= aux_n;
			auto_q  <= auto_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_s3) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign result_out.valid   = out_valid_q;
	assign result_out.payload = out_q;

endmodule

[hdl/rc_receiver_frame_decoder.sv]
// rc_receiver_frame_decoder: top level of the serial radio frame decoder
// depends on rcd_pkg, rcd_if, rcd_cfg_regs, rcd_frame_capture, rcd_scale, rcd_ref_update
//
// channel     dir  transfer                  payload
// byte_in     in   valid & ready             data_byte, frame_end
// result_out  out  valid & ready             four Q12 sticks, flags
// cfg port    in   cfg_wr_en (no handshake)  cfg_index, cfg_wr_data
//
// one byte per cycle unless stalled; a byte without frame_end only updates the capture stage
// a last byte reaches result_out via the input register, then registered stages in order:
// decode, reciprocal multiply, reference update into the output register
// stalls on result_out back up stage by stage; byte_in keeps taking bytes into free stages
// reset clears valids, count, previous byte and references; no clearing pass

module rc_receiver_frame_decoder #(
	parameter int MAX_FRAME_BYTES = rcd_pkg::MAX_FRAME_BYTES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rcd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rcd_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
	rcd_byte_if.sink                        byte_in,
	rcd_result_if.source                    result_out
);

	rcd_pkg::cfg_t    cfg;
	logic             valid_s2;
	rcd_pkg::prep_t   prep_s2;
	logic             ready_s2;
	logic             valid_s3;
	rcd_pkg::scaled_t scaled_s3;
	logic             ready_s3;

	rcd_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.cfg         (cfg)
	);

	rcd_frame_capture #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_capture (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.byte_in  (byte_in),
		.valid_s2 (valid_s2),
		.prep_s2  (prep_s2),
		.ready_dn (ready_s2)
	);

	rcd_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.prep_s2   (prep_s2),
		.ready_s2  (ready_s2),
		.valid_s3  (valid_s3),
		.scaled_s3 (scaled_s3),
		.ready_dn  (ready_s3)
	);

	rcd_ref_update u_update (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.valid_s3   (valid_s3),
		.scaled_s3  (scaled_s3),
		.ready_s3   (ready_s3),
		.result_out (result_out)
	);

endmodule
